@@ rtl/heightmap_bilinear_sampler_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the heightmap bilinear sampler
// Both macros expect signals named clk and rst in the calling scope.
// ----------------------------------------------------------------------------
`ifndef HEIGHTMAP_BILINEAR_SAMPLER_MACROS_SVH
`define HEIGHTMAP_BILINEAR_SAMPLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HBS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hbs same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hbs next-cycle assertion failed");

`endif

@@ rtl/hbs_pkg.sv @@
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared constants, types and helper functions of the heightmap sampler.
// ----------------------------------------------------------------------------
package hbs_pkg;

  // Grid geometry and position format.
  localparam int GRID_SIDE = 64;
  localparam int FRAC_BITS = 8;

  // Field widths of the transactions.
  localparam int FUNC_W   = 1;
  localparam int INDEX_W  = 12;
  localparam int SAMPLE_W = 8;
  localparam int POS_W    = 14;
  localparam int OUT_W    = 23;

  // Derived storage and datapath widths.
  localparam int DEPTH    = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int COL_W    = $clog2(GRID_SIDE);
  localparam int HGT_W    = 7;
  localparam int WX_W     = FRAC_BITS + 1;
  localparam int WT_W     = 2 * FRAC_BITS + 1;
  localparam int ACC_W    = HGT_W + WT_W;
  localparam int SH_L     = (2 * FRAC_BITS < 16) ? 16 - 2 * FRAC_BITS : 0;
  localparam int SH_R     = (2 * FRAC_BITS > 16) ? 2 * FRAC_BITS - 16 : 0;
  localparam int SCALE_W  = ACC_W + 16;

  localparam logic [WX_W-1:0] FRAC_ONE = WX_W'(1) << FRAC_BITS;

  // Function codes.
  localparam logic [FUNC_W-1:0] FUNC_LOAD   = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 1'b1;

  // Corner order: (c0,r0), (c1,r0), (c1,r1), (c0,r1).
  localparam logic [1:0] CORNER_FIRST = 2'd0;
  localparam logic [1:0] CORNER_LAST  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LAST,
    ST_DONE
  } hbs_state_t;

  typedef struct packed {
    logic       clear;
    logic       wt_en;
    logic       acc_en;
    logic [1:0] corner;
  } blend_ctl_t;

  // Corners 1 and 2 lie on the next column, corners 2 and 3 on the next row.
  function automatic logic corner_next_col(input logic [1:0] corner);
    return corner[0] ^ corner[1];
  endfunction

  function automatic logic corner_next_row(input logic [1:0] corner);
    return corner[1];
  endfunction

  // Byte divided by three: multiply by 171 and drop nine bits, exact for 0..255.
  function automatic logic [HGT_W-1:0] div3(input logic [SAMPLE_W-1:0] x);
    logic [15:0] prod;
    prod = 16'(x) * 16'd171;
    return prod[15:9];
  endfunction

endpackage

@@ rtl/hbs_if.sv @@
// ----------------------------------------------------------------------------
// hbs_cmd_if / hbs_rsp_if
// Valid/ready channels carrying command and response transactions.
// ----------------------------------------------------------------------------
interface hbs_cmd_if import hbs_pkg::*;;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [INDEX_W-1:0]  entry_index;
  logic [SAMPLE_W-1:0] entry_sample;
  logic [POS_W-1:0]    col_pos;
  logic [POS_W-1:0]    row_pos;

  modport source (
    output valid, func, entry_index, entry_sample, col_pos, row_pos,
    input  ready
  );
  modport sink (
    input  valid, func, entry_index, entry_sample, col_pos, row_pos,
    output ready
  );
endinterface

interface hbs_rsp_if import hbs_pkg::*;;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] height_out;
  logic             out_of_range;

  modport source (
    output valid, height_out, out_of_range,
    input  ready
  );
  modport sink (
    input  valid, height_out, out_of_range,
    output ready
  );
endinterface

@@ rtl/hbs_store.sv @@
// ----------------------------------------------------------------------------
// hbs_store
// Single-port height memory with a registered read port.
// ----------------------------------------------------------------------------
module hbs_store import hbs_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [HGT_W-1:0]  wdata,
  output logic [HGT_W-1:0]  rdata
);

  logic [HGT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/hbs_blend.sv @@
// ----------------------------------------------------------------------------
// hbs_blend
// Corner weight generation and multiply-accumulate of the four heights.
// ----------------------------------------------------------------------------
module hbs_blend import hbs_pkg::*; (
  input  logic                 clk,
  input  blend_ctl_t           ctl,
  input  logic [FRAC_BITS-1:0] tx,
  input  logic [FRAC_BITS-1:0] ty,
  input  logic [HGT_W-1:0]     height,
  output logic [ACC_W-1:0]     acc
);

  logic [WX_W-1:0] wx;
  logic [WX_W-1:0] wy;
  logic [WT_W-1:0] weight;

  // The weight is registered so that it meets the matching read data.
  always_comb begin
    wx = corner_next_col(ctl.corner) ? WX_W'(tx) : FRAC_ONE - WX_W'(tx);
    wy = corner_next_row(ctl.corner) ? WX_W'(ty) : FRAC_ONE - WX_W'(ty);
  end

  always_ff @(posedge clk) begin
    if (ctl.wt_en) begin
      weight <= WT_W'(wx) * WT_W'(wy);
    end
    if (ctl.clear) begin
      acc <= '0;
    end else if (ctl.acc_en) begin
      acc <= acc + ACC_W'(height) * ACC_W'(weight);
    end
  end

endmodule

@@ rtl/heightmap_bilinear_sampler.sv @@
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler
// Load item: the store is written in the acceptance cycle, then the response
// is registered. Sample item: four corner reads from the single-port height
// memory, one per cycle, then one accumulate and the registered response.
// An out-of-grid sample skips the reads. One command is worked on at a time.
// Synchronous active-high reset clears control state; the memory is kept.
// ----------------------------------------------------------------------------
module heightmap_bilinear_sampler import hbs_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  hbs_cmd_if.sink   cmd,
  hbs_rsp_if.source rsp
);

  // Sequencer state and per-transaction registers.
  hbs_state_t           state;
  hbs_state_t           state_next;
  logic [1:0]           corner;
  logic [1:0]           corner_next;
  logic [COL_W-1:0]     c0;
  logic [COL_W-1:0]     c1;
  logic [COL_W-1:0]     r0;
  logic [COL_W-1:0]     r1;
  logic [FRAC_BITS-1:0] tx;
  logic [FRAC_BITS-1:0] ty;
  logic                 oor;

  // Response register.
  logic                 rsp_valid;
  logic [OUT_W-1:0]     rsp_height;
  logic                 rsp_oor;

  // Decode of the incoming command.
  logic                 accept;
  logic                 is_load;
  logic                 load_ok;
  logic                 pos_oor;
  logic [COL_W-1:0]     c0_in;
  logic [COL_W-1:0]     r0_in;

  // Memory and blend control.
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_addr;
  logic [ADDR_W-1:0]    rd_addr;
  logic [COL_W-1:0]     rd_col;
  logic [COL_W-1:0]     rd_row;
  logic [HGT_W-1:0]     mem_rdata;
  blend_ctl_t           ctl;
  logic [ACC_W-1:0]     acc;
  logic [SCALE_W-1:0]   scaled;
  logic                 rsp_load;

  // A new command is taken only while the sequencer is idle; the response
  // register is separate, so a waiting response stalls the sequencer only in ST_DONE.
  assign cmd.ready = (state == ST_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign is_load   = (cmd.func == FUNC_LOAD);

  // Writes beyond the store are dropped, but still answered.
  assign load_ok = (32'(cmd.entry_index) < 32'(DEPTH));

  // The integer part of a position must lie inside the grid.
  assign pos_oor = (32'(cmd.col_pos >> FRAC_BITS) >= 32'(GRID_SIDE)) ||
                   (32'(cmd.row_pos >> FRAC_BITS) >= 32'(GRID_SIDE));
  assign c0_in   = COL_W'(cmd.col_pos >> FRAC_BITS);
  assign r0_in   = COL_W'(cmd.row_pos >> FRAC_BITS);

  // Corner address: the neighbour column and row were wrapped at acceptance.
  assign rd_col  = corner_next_col(corner) ? c1 : c0;
  assign rd_row  = corner_next_row(corner) ? r1 : r0;
  assign rd_addr = ADDR_W'(ADDR_W'(rd_row) * ADDR_W'(GRID_SIDE) + ADDR_W'(rd_col));

  // The single memory port is written in the acceptance cycle of a load and
  // is read in the ST_READ state of a sample, so the two never meet.
  assign mem_we   = accept && is_load && load_ok;
  assign mem_addr = mem_we ? ADDR_W'(cmd.entry_index) : rd_addr;

  // Bring the blend from 2*FRAC_BITS fraction bits to 16; loads and
  // out-of-grid samples leave the accumulator cleared, hence a zero height.
  assign scaled = (SCALE_W'(acc) << SH_L) >> SH_R;

  assign rsp_load = (state == ST_DONE) && (!rsp_valid || rsp.ready);

  // Sequencer: read one corner a cycle while the blend accumulates the
  // corner read in the cycle before.
  always_comb begin
    state_next  = state;
    corner_next = corner;
    ctl.clear   = 1'b0;
    ctl.wt_en   = 1'b0;
    ctl.acc_en  = 1'b0;
    ctl.corner  = corner;
    case (state)
      ST_IDLE: begin
        ctl.clear = accept;
        if (accept) begin
          corner_next = CORNER_FIRST;
          if (is_load || pos_oor) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_READ: begin
        ctl.wt_en   = 1'b1;
        ctl.acc_en  = (corner != CORNER_FIRST);
        corner_next = corner + 2'd1;
        if (corner == CORNER_LAST) begin
          state_next = ST_LAST;
        end
      end
      ST_LAST: begin
        ctl.acc_en = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (rsp_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      corner <= CORNER_FIRST;
    end else begin
      state  <= state_next;
      corner <= corner_next;
    end
  end

  // Capture the query geometry, wrapping a neighbour past the last column
  // or row back to zero.
  always_ff @(posedge clk) begin
    if (accept) begin
      c0  <= c0_in;
      r0  <= r0_in;
      c1  <= (32'(c0_in) == 32'(GRID_SIDE - 1)) ? '0 : c0_in + COL_W'(1);
      r1  <= (32'(r0_in) == 32'(GRID_SIDE - 1)) ? '0 : r0_in + COL_W'(1);
      tx  <= cmd.col_pos[FRAC_BITS-1:0];
      ty  <= cmd.row_pos[FRAC_BITS-1:0];
      oor <= !is_load && pos_oor;
    end
  end

  // Response register: loaded when the sequencer is done and the slot is
  // free or being emptied in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_height <= OUT_W'(scaled);
      rsp_oor    <= oor;
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.height_out   = rsp_height;
  assign rsp.out_of_range = rsp_oor;

  hbs_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (div3(cmd.entry_sample)),
    .rdata (mem_rdata)
  );

  hbs_blend u_blend (
    .clk    (clk),
    .ctl    (ctl),
    .tx     (tx),
    .ty     (ty),
    .height (mem_rdata),
    .acc    (acc)
  );

endmodule

@@ rtl/hbs_checker.sv @@
// ----------------------------------------------------------------------------
// hbs_checker
// Port-level assertions for the heightmap sampler, bound to the top level.
// ----------------------------------------------------------------------------
`include "heightmap_bilinear_sampler_macros.svh"

module hbs_checker import hbs_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             cmd_valid,
  input logic             cmd_ready,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input logic [OUT_W-1:0] rsp_height_out,
  input logic             rsp_out_of_range
);

  `HBS_ASSERT_NEXT(a_rsp_hold_valid, rsp_valid && !rsp_ready, rsp_valid)
  `HBS_ASSERT_NEXT(a_rsp_hold_data, rsp_valid && !rsp_ready, $stable(rsp_height_out))
  // Only one transaction is worked on at a time.
  `HBS_ASSERT_NEXT(a_one_at_a_time, cmd_valid && cmd_ready, !cmd_ready)
  // An out-of-grid sample never carries a height.
  `HBS_ASSERT_SAME(a_oor_zero, rsp_valid && rsp_out_of_range, rsp_height_out == '0)

endmodule

bind heightmap_bilinear_sampler hbs_checker u_checker (
  .clk              (clk),
  .rst              (rst),
  .cmd_valid        (cmd.valid),
  .cmd_ready        (cmd.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_height_out   (rsp.height_out),
  .rsp_out_of_range (rsp.out_of_range)
);

@@ verif/heightmap_bilinear_sampler_tb.sv @@
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler_tb
// Self-checking bench for the heightmap bilinear sampler. Load and sample
// transactions are sent over the command channel. Each accepted transaction
// is run through a local model of the height store and the bilinear blend,
// and every response is compared field by field with the oldest prediction.
// The sender works in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module heightmap_bilinear_sampler_tb import hbs_pkg::*;;

  // Run length guards. The cycle limit is several times the slowest correct
  // run: about 1500 transactions, each with the longest sender gap,
  // the longest sample latency and the longest receiver stall, plus the
  // long hold-off.
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int END_SLACK   = 20;
  localparam int ITEM_TARGET = 1500;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [INDEX_W-1:0]  entry_index;
    logic [SAMPLE_W-1:0] entry_sample;
    logic [POS_W-1:0]    col_pos;
    logic [POS_W-1:0]    row_pos;
  } sampler_cmd_t;

  typedef struct packed {
    logic [OUT_W-1:0] height_out;
    logic             out_of_range;
  } sampler_rsp_t;

  logic clk;
  logic rst;

  hbs_cmd_if cmd_ch ();
  hbs_rsp_if rsp_ch ();

  heightmap_bilinear_sampler u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  // Local copy of the height store, updated in the order that load
  // transactions are accepted. Only written entries are ever read.
  logic [HGT_W-1:0] height_mirror [DEPTH];

  // Which entries the stimulus has loaded so far. A sample is only sent once
  // all four of its corners are loaded, so no unwritten entry is ever read.
  bit cell_loaded [DEPTH];

  // Predicted responses, oldest first.
  sampler_rsp_t height_results_due [$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int items_sent     = 0;

  // Sender state: remaining transactions of the current burst, whether gaps
  // are inserted between bursts, and whether valid is currently driven high.
  int burst_left     = 0;
  bit sender_gaps_on = 1'b1;
  bit cmd_up         = 1'b0;

  // Set by a test to ask the receiver for one long hold-off; the receiver
  // clears it when the hold-off is over.
  bit hold_req = 1'b0;

  // Clock: period of 10 time units.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Global watchdog. A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Applies one accepted command to the local store and queues the response
  // that it should produce. A load writes byte / 3 and answers with zeros.
  // A sample blends the four surrounding heights with weights whose sum is
  // one squared in position units, then rescales to 16 fraction bits. The
  // neighbour beyond the last column or row wraps round to index 0.
  task automatic predict_height(input sampler_cmd_t c);
    sampler_rsp_t      r;
    int unsigned       c0, r0, c1, r1, tx, ty, one;
    longint unsigned   h00, h01, h11, h10, acc;
    r = '0;
    if (c.func == FUNC_LOAD) begin
      if (c.entry_index < DEPTH)
        height_mirror[c.entry_index] = HGT_W'(c.entry_sample / 3);
    end else begin
      one = 1 << FRAC_BITS;
      c0  = c.col_pos >> FRAC_BITS;
      r0  = c.row_pos >> FRAC_BITS;
      tx  = c.col_pos & (one - 1);
      ty  = c.row_pos & (one - 1);
      if (c0 >= GRID_SIDE || r0 >= GRID_SIDE) begin
        r.out_of_range = 1'b1;
      end else begin
        c1 = (c0 + 1 == GRID_SIDE) ? 0 : c0 + 1;
        r1 = (r0 + 1 == GRID_SIDE) ? 0 : r0 + 1;
        h00 = height_mirror[r0 * GRID_SIDE + c0];
        h01 = height_mirror[r0 * GRID_SIDE + c1];
        h11 = height_mirror[r1 * GRID_SIDE + c1];
        h10 = height_mirror[r1 * GRID_SIDE + c0];
        acc = h00 * (one - tx) * (one - ty)
            + h01 * tx * (one - ty)
            + h11 * tx * ty
            + h10 * (one - tx) * ty;
        if (2 * FRAC_BITS < 16)
          acc = acc << (16 - 2 * FRAC_BITS);
        else
          acc = acc >> (2 * FRAC_BITS - 16);
        r.height_out = acc[OUT_W-1:0];
      end
    end
    height_results_due.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // Response checking
  // --------------------------------------------------------------------------

  // Values are sampled at the rising edge, before any update of that edge
  // takes effect, so the comparison does not depend on process order.
  always @(posedge clk) begin
    sampler_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (height_results_due.size() == 0) begin
        $error("unexpected response transaction: height_out %0d, out_of_range %0d",
               rsp_ch.height_out, rsp_ch.out_of_range);
        mismatch_count++;
      end else begin
        want = height_results_due.pop_front();
        if (rsp_ch.height_out !== want.height_out) begin
          $error("height_out mismatch: expected %0d, actual %0d",
                 want.height_out, rsp_ch.height_out);
          mismatch_count++;
        end
        if (rsp_ch.out_of_range !== want.out_of_range) begin
          $error("out_of_range mismatch: expected %0d, actual %0d",
                 want.out_of_range, rsp_ch.out_of_range);
          mismatch_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver
  // --------------------------------------------------------------------------

  // The receiver runs through segments of its own: always ready, random
  // ready, a regular one-in-four stall, or a short full stall. A request
  // from a test replaces this with one long hold-off, counted here.
  initial begin
    int mode;
    int len;
    int k;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        len  = (mode == 3) ? $urandom_range(1, 6) : $urandom_range(4, 40);
        for (k = 0; k < len && !hold_req; k++) begin
          case (mode)
            0: begin
              rsp_ch.ready <= 1'b1;
            end
            1: begin
              rsp_ch.ready <= 1'($urandom_range(0, 1));
            end
            2: begin
              rsp_ch.ready <= (k % 4 != 3);
            end
            default: begin
              rsp_ch.ready <= 1'b0;
            end
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------

  // Offers one command and returns at the edge where it is accepted. Valid
  // stays high into the next transaction of a burst; between bursts it is
  // lowered for a random gap. With gaps switched off valid is never lowered
  // here, so it is never dropped and raised in the same time step.
  task automatic send_item(input sampler_cmd_t c);
    if (burst_left == 0) begin
      if (sender_gaps_on) begin
        if (cmd_up) begin
          cmd_ch.valid <= 1'b0;
          cmd_up = 1'b0;
        end
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.func         <= c.func;
    cmd_ch.entry_index  <= c.entry_index;
    cmd_ch.entry_sample <= c.entry_sample;
    cmd_ch.col_pos      <= c.col_pos;
    cmd_ch.row_pos      <= c.row_pos;
    cmd_up = 1'b1;
    do @(posedge clk); while (!cmd_ch.ready);
    predict_height(c);
    burst_left--;
    items_sent++;
  endtask

  // Lowers valid once the last transaction of a phase has been accepted.
  task automatic release_cmd();
    if (cmd_up) begin
      cmd_ch.valid <= 1'b0;
      cmd_up = 1'b0;
    end
  endtask

  task automatic wait_drained();
    while (height_results_due.size() != 0) @(posedge clk);
  endtask

  // Position fields carry unrelated random content on load transactions, and
  // index and sample fields do so on sample transactions.
  task automatic load_entry(input int unsigned idx, input int unsigned raw);
    sampler_cmd_t c;
    c.func         = FUNC_LOAD;
    c.entry_index  = INDEX_W'(idx);
    c.entry_sample = SAMPLE_W'(raw);
    c.col_pos      = POS_W'($urandom);
    c.row_pos      = POS_W'($urandom);
    cell_loaded[idx] = 1'b1;
    send_item(c);
  endtask

  // Sends a sample at the given position, loading any of its four corners
  // that have not been written yet, wrapped neighbours included.
  task automatic sample_at(input int unsigned col, input int unsigned row);
    sampler_cmd_t c;
    int unsigned  c0, r0, c1, r1;
    int unsigned  corner_idx [4];
    c0 = col >> FRAC_BITS;
    r0 = row >> FRAC_BITS;
    c1 = (c0 + 1) % GRID_SIDE;
    r1 = (r0 + 1) % GRID_SIDE;
    corner_idx[0] = r0 * GRID_SIDE + c0;
    corner_idx[1] = r0 * GRID_SIDE + c1;
    corner_idx[2] = r1 * GRID_SIDE + c1;
    corner_idx[3] = r1 * GRID_SIDE + c0;
    foreach (corner_idx[i])
      if (!cell_loaded[corner_idx[i]])
        load_entry(corner_idx[i], $urandom_range(0, 255));
    c.func         = FUNC_SAMPLE;
    c.entry_index  = INDEX_W'($urandom);
    c.entry_sample = SAMPLE_W'($urandom);
    c.col_pos      = POS_W'(col);
    c.row_pos      = POS_W'(row);
    send_item(c);
  endtask

  // Fraction within a cell, biased towards the two ends.
  function automatic int unsigned pick_fraction();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0)
      return 0;
    else if (sel == 1)
      return (1 << FRAC_BITS) - 1;
    return $urandom_range(0, (1 << FRAC_BITS) - 1);
  endfunction

  function automatic int unsigned cell_pos(input int unsigned grid_cell,
                                           input int unsigned frac);
    return (grid_cell << FRAC_BITS) | frac;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Raw bytes at both ends and near the rounding steps of the division by
  // three, placed at the grid corners so that the wrapped samples that
  // follow read known values.
  task automatic test_load_extremes();
    load_entry(0, 255);
    load_entry(1, 0);
    load_entry(GRID_SIDE, 1);
    load_entry(GRID_SIDE + 1, 2);
    load_entry(GRID_SIDE - 1, 3);
    load_entry(2 * GRID_SIDE - 1, 254);
    load_entry(DEPTH - GRID_SIDE, 128);
    load_entry(DEPTH - GRID_SIDE + 1, 170);
    load_entry(DEPTH - 1, 85);
    load_entry(DEPTH - 1, 253);
  endtask

  // Exact grid points, fractions at both ends, and the wrap of the column
  // neighbour, the row neighbour and both at once. With 14-bit positions and
  // 8 fraction bits the cell never reaches the grid side, so the
  // out-of-grid response cannot be provoked at this configuration.
  task automatic test_corner_queries();
    int unsigned top;
    top = (1 << POS_W) - 1;
    sample_at(0, 0);
    sample_at(cell_pos(0, 255), cell_pos(0, 255));
    sample_at(cell_pos(0, 128), cell_pos(0, 64));
    sample_at(0, cell_pos(0, 255));
    sample_at(cell_pos(0, 255), 0);
    sample_at(top, 0);
    sample_at(0, top);
    sample_at(top, top);
    sample_at(cell_pos(GRID_SIDE - 1, 0), cell_pos(GRID_SIDE - 1, 0));
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering back-to-back transactions, so the block fills and stalls its
  // command channel.
  task automatic test_input_stall();
    int unsigned base_c, base_r;
    bit          gaps_saved;
    gaps_saved     = sender_gaps_on;
    sender_gaps_on = 1'b0;
    base_c         = $urandom_range(0, GRID_SIDE - 1);
    base_r         = $urandom_range(0, GRID_SIDE - 1);
    hold_req       = 1'b1;
    repeat (48)
      sample_at(cell_pos((base_c + $urandom_range(0, 2)) % GRID_SIDE, pick_fraction()),
                cell_pos((base_r + $urandom_range(0, 2)) % GRID_SIDE, pick_fraction()));
    sender_gaps_on = gaps_saved;
  endtask

  // The sender pauses until every outstanding response has been checked,
  // then resumes with a burst on an empty pipeline.
  task automatic test_drain_pause();
    release_cmd();
    wait_drained();
    burst_left = 0;
    repeat (8) sample_at($urandom_range(0, (1 << POS_W) - 1) & ~32'h0,
                         $urandom_range(0, (1 << POS_W) - 1));
  endtask

  // Mostly samples inside a small moving window of cells, so that the store
  // fills where it is used and most samples need no fresh loads; also
  // samples on the last row and column for the wrap, overwrites of loaded
  // entries, and loads anywhere in the store.
  task automatic test_random_mix(input int target);
    int unsigned win_c, win_r, c, r, sel;
    int          next_move;
    next_move = items_sent;
    while (items_sent < target) begin
      if (items_sent >= next_move) begin
        win_c          = $urandom_range(0, GRID_SIDE - 1);
        win_r          = $urandom_range(0, GRID_SIDE - 1);
        sender_gaps_on = ($urandom_range(0, 3) != 0);
        next_move      = items_sent + 100;
      end
      sel = $urandom_range(0, 99);
      c   = (win_c + $urandom_range(0, 7)) % GRID_SIDE;
      r   = (win_r + $urandom_range(0, 7)) % GRID_SIDE;
      if (sel < 60) begin
        sample_at(cell_pos(c, pick_fraction()), cell_pos(r, pick_fraction()));
      end else if (sel < 70) begin
        c = $urandom_range(0, 1) ? GRID_SIDE - 1 : $urandom_range(0, GRID_SIDE - 1);
        r = $urandom_range(0, 1) ? GRID_SIDE - 1 : $urandom_range(0, GRID_SIDE - 1);
        if (c != GRID_SIDE - 1 && r != GRID_SIDE - 1)
          c = GRID_SIDE - 1;
        sample_at(cell_pos(c, pick_fraction()), cell_pos(r, pick_fraction()));
      end else if (sel < 90) begin
        load_entry(r * GRID_SIDE + c, $urandom_range(0, 255));
      end else begin
        load_entry($urandom_range(0, DEPTH - 1), $urandom_range(0, 255));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    rst                 <= 1'b1;
    cmd_ch.valid        <= 1'b0;
    cmd_ch.func         <= FUNC_LOAD;
    cmd_ch.entry_index  <= '0;
    cmd_ch.entry_sample <= '0;
    cmd_ch.col_pos      <= '0;
    cmd_ch.row_pos      <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_load_extremes();
    test_corner_queries();
    test_input_stall();
    test_random_mix(ITEM_TARGET / 2);
    test_drain_pause();
    test_random_mix(ITEM_TARGET);

    // All commands are in; wait for the last responses, then allow a few
    // cycles for any stray response to show up.
    release_cmd();
    wait_drained();
    repeat (END_SLACK) @(posedge clk);

    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
